>>> rtl/core/tlvp_pkg.sv
// Shared types and constants of the TLV record parser.
// Used by the channel interfaces and by every module in rtl/core.
package tlvp_pkg;

    localparam int LENGTH_BITS_DEF = 16;
    localparam int HEADER_BYTES    = 4;

    localparam int KIND_W = 3;
    localparam int TAG_W  = 16;
    localparam int LEN_W  = 16;
    localparam int BYTE_W = 8;

    localparam logic [KIND_W-1:0] KIND_HDR_BYTE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_HDR_DONE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_VALUE    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_END      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TRUNC    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_OVERRUN  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_IGNORED  = 3'd6;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag;
        logic [LEN_W-1:0]  value_length;
        logic [BYTE_W-1:0] value_byte;
        logic              last;
    } t_result;

    typedef struct packed {
        logic    valid;
        logic    two;
        t_result res0;
        t_result res1;
    } t_push;

endpackage

>>> rtl/core/tlvp_channels.sv
// Channel interfaces of the TLV record parser: byte input, result output
// and buffer length write. Depends on tlvp_pkg for field widths.
interface tlvp_byte_if;
    import tlvp_pkg::*;
    logic              valid;
    logic              ready;
    logic              start_req;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output start_req, output data_byte, input ready);
    modport sink (input valid, input start_req, input data_byte, output ready);
endinterface

interface tlvp_rec_if;
    import tlvp_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  tag;
    logic [LEN_W-1:0]  value_length;
    logic [BYTE_W-1:0] value_byte;
    logic              last;

    modport source (output valid, output kind, output tag, output value_length,
                    output value_byte, output last, input ready);
    modport sink (input valid, input kind, input tag, input value_length,
                  input value_byte, input last, output ready);
endinterface

interface tlvp_cfg_if;
    import tlvp_pkg::*;
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] buffer_length;

    modport source (output valid, output buffer_length, input ready);
    modport sink (input valid, input buffer_length, output ready);
endinterface

>>> rtl/core/tlvp_parse.sv
// Parse state and the single-pass classification of one byte into one or
// two results. Depends on tlvp_pkg.
module tlvp_parse
    import tlvp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  logic                   i_start,
    input  logic [BYTE_W-1:0]      i_byte,
    input  logic [LENGTH_BITS-1:0] i_buf_len,
    output t_push                  o_push
);

    localparam int CUR_W = LENGTH_BITS + 1;
    localparam int SUM_W = ((CUR_W > LEN_W) ? CUR_W : LEN_W) + 1;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_VALUE  = 2'd1;
    localparam logic [1:0] PH_STOP   = 2'd2;

    localparam logic [1:0] HDR_LAST = 2'(HEADER_BYTES - 1);

    logic [CUR_W-1:0] r_cursor, n_cursor;
    logic [1:0]       r_phase, n_phase;
    logic [1:0]       r_hidx, n_hidx;
    logic [TAG_W-1:0] r_tag, n_tag;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_rem, n_rem;

    always_comb begin
        logic [CUR_W-1:0] cur_eff;
        logic [CUR_W-1:0] cur_inc;
        logic [1:0]       ph_eff;
        logic [1:0]       hidx_eff;
        logic [TAG_W-1:0] tag_eff;
        logic [LEN_W-1:0] len_eff;
        logic [LEN_W-1:0] rem_eff;
        logic [LEN_W-1:0] rem_dec;
        logic [SUM_W-1:0] sum_hdr;
        logic [SUM_W-1:0] sum_len;

        cur_eff  = i_start ? '0 : r_cursor;
        ph_eff   = i_start ? PH_HEADER : r_phase;
        hidx_eff = i_start ? 2'd0 : r_hidx;
        tag_eff  = i_start ? '0 : r_tag;
        len_eff  = i_start ? '0 : r_len;
        rem_eff  = i_start ? '0 : r_rem;
        cur_inc  = cur_eff + CUR_W'(1);
        rem_dec  = (rem_eff != '0) ? rem_eff - LEN_W'(1) : '0;

        n_cursor = cur_eff;
        n_phase  = ph_eff;
        n_hidx   = hidx_eff;
        n_tag    = tag_eff;
        n_len    = len_eff;
        n_rem    = rem_eff;

        case (hidx_eff)
            2'd0: n_tag = {8'h00, i_byte};
            2'd1: n_tag = {i_byte, tag_eff[7:0]};
            2'd2: n_len = {8'h00, i_byte};
            default: n_len = {i_byte, len_eff[7:0]};
        endcase

        sum_hdr = SUM_W'(cur_eff) + SUM_W'(HEADER_BYTES);
        sum_len = SUM_W'(cur_inc) + SUM_W'(n_len);

        o_push       = '0;
        o_push.valid = i_fire;

        case (ph_eff)
            PH_HEADER: begin
                if (hidx_eff == 2'd0 && cur_eff == CUR_W'(i_buf_len)) begin
                    o_push.res0.kind = KIND_END;
                    n_phase          = PH_STOP;
                    n_tag            = tag_eff;
                    n_len            = len_eff;
                end else if (hidx_eff == 2'd0 && sum_hdr > SUM_W'(i_buf_len)) begin
                    o_push.res0.kind = KIND_TRUNC;
                    n_phase          = PH_STOP;
                    n_tag            = tag_eff;
                    n_len            = len_eff;
                end else begin
                    n_cursor = cur_inc;
                    if (hidx_eff != HDR_LAST) begin
                        n_hidx           = hidx_eff + 2'd1;
                        o_push.res0.kind = KIND_HDR_BYTE;
                    end else begin
                        n_hidx                   = 2'd0;
                        o_push.res0.kind         = KIND_HDR_DONE;
                        o_push.res0.tag          = n_tag;
                        o_push.res0.value_length = n_len;
                        if (sum_len > SUM_W'(i_buf_len)) begin
                            o_push.two       = 1'b1;
                            o_push.res1.kind = KIND_OVERRUN;
                            n_phase          = PH_STOP;
                        end else if (n_len == '0) begin
                            if (cur_inc == CUR_W'(i_buf_len)) begin
                                o_push.two       = 1'b1;
                                o_push.res1.kind = KIND_END;
                                n_phase          = PH_STOP;
                            end
                        end else begin
                            n_rem   = n_len;
                            n_phase = PH_VALUE;
                        end
                    end
                end
            end
            PH_VALUE: begin
                n_tag                    = tag_eff;
                n_len                    = len_eff;
                o_push.res0.kind         = KIND_VALUE;
                o_push.res0.tag          = tag_eff;
                o_push.res0.value_length = len_eff;
                o_push.res0.value_byte   = i_byte;
                n_cursor                 = cur_inc;
                n_rem                    = rem_dec;
                if (rem_dec == '0) begin
                    n_phase = PH_HEADER;
                    n_hidx  = 2'd0;
                    if (cur_inc == CUR_W'(i_buf_len)) begin
                        o_push.two       = 1'b1;
                        o_push.res1.kind = KIND_END;
                        n_phase          = PH_STOP;
                    end
                end
            end
            default: begin
                n_tag            = tag_eff;
                n_len            = len_eff;
                o_push.res0.kind = KIND_IGNORED;
            end
        endcase

        o_push.res0.last = !o_push.two;
        o_push.res1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_phase  <= PH_HEADER;
            r_hidx   <= 2'd0;
            r_tag    <= '0;
            r_len    <= '0;
            r_rem    <= '0;
        end else if (i_fire) begin
            r_cursor <= n_cursor;
            r_phase  <= n_phase;
            r_hidx   <= n_hidx;
            r_tag    <= n_tag;
            r_len    <= n_len;
            r_rem    <= n_rem;
        end
    end

endmodule

>>> rtl/core/tlvp_outq.sv
// Three-entry result queue that takes one or two results per parsed byte
// and drives the result channel. Depends on tlvp_pkg and tlvp_rec_if.
module tlvp_outq
    import tlvp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_push             i_push,
    output logic              o_room,
    tlvp_rec_if.source        o_rec
);

    localparam int DEPTH = 3;

    t_result    r_q [DEPTH];
    t_result    n_q [DEPTH];
    logic [1:0] r_cnt, n_cnt;
    logic       pop;

    assign pop    = o_rec.valid && o_rec.ready;
    assign o_room = (r_cnt <= 2'd1);

    assign o_rec.valid        = (r_cnt != 2'd0);
    assign o_rec.kind         = r_q[0].kind;
    assign o_rec.tag          = r_q[0].tag;
    assign o_rec.value_length = r_q[0].value_length;
    assign o_rec.value_byte   = r_q[0].value_byte;
    assign o_rec.last         = r_q[0].last;

    always_comb begin
        logic [1:0] wr_idx;

        wr_idx = r_cnt - 2'(pop);
        for (int i = 0; i < DEPTH; i++) begin
            if (pop && i < DEPTH - 1) begin
                n_q[i] = r_q[i + 1];
            end else begin
                n_q[i] = r_q[i];
            end
            if (i_push.valid && wr_idx == 2'(i)) begin
                n_q[i] = i_push.res0;
            end
            if (i_push.valid && i_push.two && wr_idx + 2'd1 == 2'(i)) begin
                n_q[i] = i_push.res1;
            end
        end
        n_cnt = wr_idx;
        if (i_push.valid) begin
            n_cnt = wr_idx + 2'd1 + 2'(i_push.two);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

endmodule

>>> rtl/core/tlv_record_parser.sv
// Top level of the TLV record parser: input register, buffer length
// register, parse stage and result queue. Depends on tlvp_pkg,
// tlvp_channels, tlvp_parse and tlvp_outq.
//
//   Channel   Direction  Payload                                        Transfer
//   i_byte    in         start_req, data_byte                           valid & ready
//   o_rec     out        kind, tag, value_length, value_byte, last      valid & ready
//   i_cfg     in         buffer_length                                  valid & ready
//
// A byte passes the input register and the result queue on its way to o_rec. One
// byte is accepted every cycle while the result queue has room; a byte with two
// results holds the parse stage until the single read port of the queue has drained
// it. Reset is synchronous and active low and clears the parse state and the buffer
// length. i_byte.ready depends only on registered state, never on o_rec.ready, and
// is high while the input register is empty or the queue holds at most one result.
module tlv_record_parser
    import tlvp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tlvp_byte_if.sink   i_byte,
    tlvp_cfg_if.sink    i_cfg,
    tlvp_rec_if.source  o_rec
);

    logic                   r_in_valid;
    logic                   r_in_start;
    logic [BYTE_W-1:0]      r_in_byte;
    logic [LENGTH_BITS-1:0] r_buf_len;
    logic                   room;
    logic                   fire;
    t_push                  push;

    assign fire         = r_in_valid && room;
    assign i_byte.ready = !r_in_valid || fire;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_start <= i_byte.start_req;
            r_in_byte  <= i_byte.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_len <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_buf_len <= LENGTH_BITS'(i_cfg.buffer_length);
        end
    end

    tlvp_parse #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_start   (r_in_start),
        .i_byte    (r_in_byte),
        .i_buf_len (r_buf_len),
        .o_push    (push)
    );

    tlvp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_rec   (o_rec)
    );

`ifndef SYNTHESIS
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_rec.valid)
        else $error("parsed byte left no result in the queue");

    a_start_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in_start |-> push.res0.kind == KIND_HDR_BYTE
            || push.res0.kind == KIND_END || push.res0.kind == KIND_TRUNC)
        else $error("first byte of a buffer misclassified");

    a_pair_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && push.two |-> push.res0.kind == KIND_HDR_DONE
            || push.res0.kind == KIND_VALUE)
        else $error("two results from a byte that cannot end a header or record");
`endif

endmodule
